// ----- rtl/rebi_pkg.sv -----
// Package for the rotary encoder and button interface.
// Holds opcodes, register map, result codes, shared structs and the quadrature table.
// No dependencies; every other file imports it.
package rebi_pkg;

	// Widths of the counters and the register port
	localparam int CNT_W   = 16;
	localparam int SPN_W   = 4;
	localparam int DEB_W   = 10;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Command opcodes
	typedef enum logic [2:0] {
		OP_PIN   = 3'd0,
		OP_TICK  = 3'd1,
		OP_TURN  = 3'd2,
		OP_STEPS = 3'd3,
		OP_CLICK = 3'd4,
		OP_HOLD  = 3'd5
	} op_t;

	// Turn direction codes
	localparam logic [1:0] TURN_NONE  = 2'd0;
	localparam logic [1:0] TURN_RIGHT = 2'd1;
	localparam logic [1:0] TURN_LEFT  = 2'd2;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_SPN    = 2'd0;
	localparam logic [1:0] REG_DEB    = 2'd1;
	localparam logic [1:0] REG_HOLD   = 2'd2;
	localparam logic [1:0] REG_INVERT = 2'd3;

	// Reset values of the registers
	localparam logic [SPN_W-1:0] SPN_RST  = 4'd4;
	localparam logic [DEB_W-1:0] DEB_RST  = 10'd20;
	localparam logic [CNT_W-1:0] HOLD_RST = 16'd1000;

	typedef struct packed {
		logic [SPN_W-1:0] spn;
		logic [DEB_W-1:0] debounce;
		logic [CNT_W-1:0] hold;
		logic             invert;
	} cfg_t;

	// Button unit control and status
	typedef struct packed {
		logic tick;
		logic raw;
		logic take_click;
		logic check_hold;
	} btn_ctrl_t;

	typedef struct packed {
		logic pressed;
		logic click;
		logic hold;
	} btn_stat_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Quadrature transition table, index = {prev_ab, cur_ab}
	function automatic logic signed [1:0] qstep(input logic [3:0] idx);
		logic signed [1:0] d;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14:  d = 2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: d = -2'sd1;
			default:                  d = 2'sd0;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/rebi_if.sv -----
// Valid/ready channel interfaces for commands and results.
// Depends on rebi_pkg for field widths.
interface rebi_cmd_if;
	import rebi_pkg::*;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic       pin_a;
	logic       pin_b;
	logic       button_down;

	modport source (output valid, op, pin_a, pin_b, button_down, input ready);
	modport sink   (input valid, op, pin_a, pin_b, button_down, output ready);
endinterface

interface rebi_rsp_if;
	import rebi_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              turn_dir;
	logic signed [CNT_W-1:0] steps_value;
	logic                    click;
	logic                    hold;
	logic                    pressed;

	modport source (output valid, turn_dir, steps_value, click, hold, pressed, input ready);
	modport sink   (input valid, turn_dir, steps_value, click, hold, pressed, output ready);
endinterface

// ----- rtl/rebi_apb_regs.sv -----
// APB register block: steps per notch, debounce, hold threshold, invert.
// Depends on rebi_pkg.
module rebi_apb_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rebi_pkg::PADDR_W-1:0]    paddr,
	input  logic [rebi_pkg::PDATA_W-1:0]    pwdata,
	output logic [rebi_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	output rebi_pkg::cfg_t                  cfg
);
	import rebi_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr;

	assign idx    = paddr[3:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spn      <= SPN_RST;
			cfg_q.debounce <= DEB_RST;
			cfg_q.hold     <= HOLD_RST;
			cfg_q.invert   <= 1'b0;
		end else if (wr) begin
			case (idx)
				REG_SPN:    cfg_q.spn      <= pwdata[SPN_W-1:0];
				REG_DEB:    cfg_q.debounce <= pwdata[DEB_W-1:0];
				REG_HOLD:   cfg_q.hold     <= pwdata[CNT_W-1:0];
				REG_INVERT: cfg_q.invert   <= pwdata[0];
				default:    ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_SPN:    prdata[SPN_W-1:0] = cfg_q.spn;
			REG_DEB:    prdata[DEB_W-1:0] = cfg_q.debounce;
			REG_HOLD:   prdata[CNT_W-1:0] = cfg_q.hold;
			REG_INVERT: prdata[0]         = cfg_q.invert;
			default:    prdata = '0;
		endcase
	end

endmodule

// ----- rtl/rebi_div.sv -----
// Restoring divider, one quotient bit per cycle: 16-bit dividend by 4-bit divisor.
// Depends on rebi_pkg.
module rebi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rebi_pkg::CNT_W-1:0]    dividend,
	input  logic [rebi_pkg::SPN_W-1:0]    divisor,
	output rebi_pkg::div_stat_t           stat,
	output logic [rebi_pkg::CNT_W-1:0]    quot,
	output logic [rebi_pkg::SPN_W-1:0]    rem
);
	import rebi_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [3:0]       cnt_q;
	logic [CNT_W-1:0] quo_q;
	logic [SPN_W-1:0] rem_q;
	logic [SPN_W-1:0] dsr_q;

	logic [SPN_W:0]   trial;
	logic [SPN_W:0]   diff;
	logic             ge;

	// one compare-subtract step
	assign trial = {rem_q, quo_q[CNT_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(CNT_W - 1);
				quo_q  <= dividend;
				rem_q  <= '0;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				quo_q <= {quo_q[CNT_W-2:0], ge};
				rem_q <= ge ? diff[SPN_W-1:0] : trial[SPN_W-1:0];
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;
	assign rem       = rem_q;

endmodule

// ----- rtl/rebi_button.sv -----
// Button debouncer with click arming, hold timing and the click/hold read events.
// Depends on rebi_pkg.
module rebi_button (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rebi_pkg::btn_ctrl_t           ctrl,
	input  logic [rebi_pkg::DEB_W-1:0]    debounce,
	input  logic [rebi_pkg::CNT_W-1:0]    hold_ticks,
	output rebi_pkg::btn_stat_t           stat
);
	import rebi_pkg::*;

	logic             last_raw_q;
	logic             stable_q;
	logic [CNT_W-1:0] since_q;
	logic [CNT_W-1:0] press_q;
	logic             timing_q;
	logic             armed_q;
	logic             click_rdy_q;
	logic             fired_q;

	logic [CNT_W-1:0] since_inc;
	logic [CNT_W-1:0] since_nxt;
	logic [CNT_W-1:0] press_inc;
	logic             accept_lvl;
	logic             hold_hit;

	// saturating timers, raw change restarts the debounce window
	assign since_inc  = (since_q == '1) ? since_q : since_q + 16'd1;
	assign press_inc  = (timing_q && press_q != '1) ? press_q + 16'd1 : press_q;
	assign since_nxt  = (ctrl.raw != last_raw_q) ? '0 : since_inc;
	assign accept_lvl = (since_nxt >= {6'd0, debounce}) && (ctrl.raw != stable_q);
	assign hold_hit   = stable_q && timing_q && !fired_q && (press_q >= hold_ticks);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= 1'b0;
			stable_q    <= 1'b0;
			since_q     <= '0;
			press_q     <= '0;
			timing_q    <= 1'b0;
			armed_q     <= 1'b0;
			click_rdy_q <= 1'b0;
			fired_q     <= 1'b0;
		end else begin
			if (ctrl.tick) begin
				last_raw_q <= ctrl.raw;
				since_q    <= since_nxt;
				press_q    <= press_inc;
				if (accept_lvl) begin
					stable_q <= ctrl.raw;
					press_q  <= '0;
					timing_q <= ctrl.raw;
					armed_q  <= ctrl.raw;
					if (!ctrl.raw) begin
						fired_q <= 1'b0;
						if (armed_q) click_rdy_q <= 1'b1;
					end
				end
			end
			if (ctrl.take_click) click_rdy_q <= 1'b0;
			if (ctrl.check_hold && hold_hit) fired_q <= 1'b1;
		end
	end

	assign stat.pressed = stable_q;
	assign stat.click   = click_rdy_q;
	assign stat.hold    = hold_hit;

endmodule

// ----- rtl/rotary_encoder_button_interface.sv -----
// Channel   Dir  Payload                                         Handshake
// cmd       in   op, pin_a, pin_b, button_down                   valid/ready
// rsp       out  turn_dir, steps_value, click, hold, pressed     valid/ready
// apb       in   notch_size, debounce, hold, invert              psel/penable, pready=1
//
// Pin samples and read ops finish in the cycle they are accepted; the result
// is registered and shows in the cycle after. A tick runs the notch divider,
// one quotient bit per cycle, and its result is registered once the divider is done.
// cmd.ready is low while a tick divides or a result waits and rsp.ready is low.
// Reset clears all counters and flags; registers return to their defaults.
// Top level: quadrature decoder, notch accumulator and command sequencer.
// Depends on rebi_pkg, rebi_if, rebi_apb_regs, rebi_div, rebi_button.
module rotary_encoder_button_interface (
	input  logic                          clk,
	input  logic                          arst_n,
	rebi_cmd_if.sink                      cmd,
	rebi_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rebi_pkg::PADDR_W-1:0]  paddr,
	input  logic [rebi_pkg::PDATA_W-1:0]  pwdata,
	output logic [rebi_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import rebi_pkg::*;

	typedef enum logic {ST_IDLE, ST_DIV} state_t;

	state_t                  state_q;
	logic [1:0]              prev_ab_q;
	logic                    dec_rdy_q;
	logic signed [CNT_W-1:0] micro_q;
	logic signed [CNT_W-1:0] notch_q;
	logic                    out_valid_q;
	logic [1:0]              turn_q;
	logic signed [CNT_W-1:0] steps_q;
	logic                    click_q;
	logic                    hold_q;

	cfg_t             cfg;
	btn_ctrl_t        btn_ctrl;
	btn_stat_t        btn_stat;
	div_stat_t        div_stat;
	logic [CNT_W-1:0] div_quot;
	logic [SPN_W-1:0] div_rem;
	logic [CNT_W-1:0] micro_abs;
	logic [SPN_W-1:0] spn_eff;

	logic                    accept;
	logic                    is_tick;
	logic [1:0]              cur_ab;
	logic signed [1:0]       dstep;
	logic signed [CNT_W:0]   micro_sum;
	logic signed [CNT_W-1:0] micro_sat;
	logic signed [CNT_W+1:0] notch_sum;
	logic signed [CNT_W-1:0] notch_sat;
	logic signed [CNT_W-1:0] micro_left;

	// configuration registers
	rebi_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake
	assign cmd.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = cmd.valid && cmd.ready;
	assign is_tick   = accept && (cmd.op == OP_TICK);

	// button unit
	assign btn_ctrl.tick       = is_tick;
	assign btn_ctrl.raw        = cmd.button_down;
	assign btn_ctrl.take_click = accept && (cmd.op == OP_CLICK);
	assign btn_ctrl.check_hold = accept && (cmd.op == OP_HOLD);

	rebi_button u_button (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (btn_ctrl),
		.debounce   (cfg.debounce),
		.hold_ticks (cfg.hold),
		.stat       (btn_stat)
	);

	// notch divider: |micro| / steps per notch, zero treated as one
	assign micro_abs = micro_q[CNT_W-1] ? CNT_W'(-micro_q) : micro_q;
	assign spn_eff   = (cfg.spn == '0) ? 4'd1 : cfg.spn;

	rebi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (is_tick),
		.dividend (micro_abs),
		.divisor  (spn_eff),
		.stat     (div_stat),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// quadrature step and saturating micro-step add
	assign cur_ab    = {cmd.pin_a, cmd.pin_b};
	assign dstep     = cfg.invert ? -qstep({prev_ab_q, cur_ab}) : qstep({prev_ab_q, cur_ab});
	assign micro_sum = {micro_q[CNT_W-1], micro_q} + {{(CNT_W-1){dstep[1]}}, dstep};
	always_comb begin
		if (micro_sum > 17'sd32767)       micro_sat = 16'sh7FFF;
		else if (micro_sum < -17'sd32768) micro_sat = -16'sh8000;
		else                              micro_sat = micro_sum[CNT_W-1:0];
	end

	// notch update from the divider result; remainder keeps the sign
	always_comb begin
		if (micro_q[CNT_W-1]) begin
			notch_sum  = {{2{notch_q[CNT_W-1]}}, notch_q} - {2'b00, div_quot};
			micro_left = -{{(CNT_W-SPN_W){1'b0}}, div_rem};
		end else begin
			notch_sum  = {{2{notch_q[CNT_W-1]}}, notch_q} + {2'b00, div_quot};
			micro_left = {{(CNT_W-SPN_W){1'b0}}, div_rem};
		end
		if (notch_sum > 18'sd32767)       notch_sat = 16'sh7FFF;
		else if (notch_sum < -18'sd32768) notch_sat = -16'sh8000;
		else                              notch_sat = notch_sum[CNT_W-1:0];
	end

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_ab_q   <= '0;
			dec_rdy_q   <= 1'b0;
			micro_q     <= '0;
			notch_q     <= '0;
			out_valid_q <= 1'b0;
			turn_q      <= TURN_NONE;
			steps_q     <= '0;
			click_q     <= 1'b0;
			hold_q      <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						turn_q      <= TURN_NONE;
						steps_q     <= '0;
						click_q     <= 1'b0;
						hold_q      <= 1'b0;
						out_valid_q <= 1'b1;
						case (cmd.op)
							OP_PIN: begin
								if (!dec_rdy_q) begin
									prev_ab_q <= cur_ab;
									dec_rdy_q <= 1'b1;
								end else if (cur_ab != prev_ab_q) begin
									prev_ab_q <= cur_ab;
									micro_q   <= micro_sat;
								end
							end
							OP_TICK: begin
								out_valid_q <= 1'b0;
								state_q     <= ST_DIV;
							end
							OP_TURN: begin
								if (notch_q > 16'sd0) begin
									notch_q <= notch_q - 16'sd1;
									turn_q  <= TURN_RIGHT;
								end else if (notch_q < 16'sd0) begin
									notch_q <= notch_q + 16'sd1;
									turn_q  <= TURN_LEFT;
								end
							end
							OP_STEPS: begin
								steps_q <= notch_q;
								notch_q <= '0;
							end
							OP_CLICK: click_q <= btn_stat.click;
							OP_HOLD:  hold_q  <= btn_stat.hold;
							default:  ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						micro_q     <= micro_left;
						notch_q     <= notch_sat;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.turn_dir    = turn_q;
	assign rsp.steps_value = steps_q;
	assign rsp.click       = click_q;
	assign rsp.hold        = hold_q;
	assign rsp.pressed     = btn_stat.pressed;

	// a tick never produces its result in the following cycle
	a_tick_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick |=> !out_valid_q)
		else $error("tick result appeared before the divider finished");

	// no command is taken while the divider runs
	a_div_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !cmd.ready)
		else $error("command accepted during division");

	// while dividing no result is held in the output register
	a_div_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !out_valid_q)
		else $error("result pending during division");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for rotary_encoder_button_interface.
// Drives pin samples, ticks and read commands, predicts each response, checks every field.
// Depends on rebi_pkg and rebi_if from the RTL.
module testbench;
	import rebi_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 24;
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic       pin_a;
		logic       pin_b;
		logic       button_down;
	} enc_cmd_t;

	typedef struct {
		logic [1:0]              turn_dir;
		logic signed [CNT_W-1:0] steps_value;
		logic                    click;
		logic                    hold;
		logic                    pressed;
	} enc_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	rebi_cmd_if cmd_ch ();
	rebi_rsp_if rsp_ch ();

	rotary_encoder_button_interface dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Command stream and awaited responses
	enc_cmd_t    encoder_cmds[$];
	enc_result_t awaited_results[$];

	// Shadow registers
	int cfg_spn, cfg_debounce, cfg_hold, cfg_invert;

	// Shadow state of the decoder and button logic
	int micro_acc, notch_acc, enc_prev;
	bit enc_primed;
	bit btn_last_raw, btn_stable, press_active, click_armed, click_pending, hold_done;
	int quiet_ticks, press_ticks;

	// Stimulus bookkeeping
	int gen_pos;
	bit gen_btn;
	bit gaps_on;
	int tx_gap, rx_stall, seg_left, tx_gap_pct, rx_gap_pct;
	int idle_cycles;
	int fail_count, results_checked, config_count;
	int turns_seen, clicks_seen, holds_seen;
	enc_cmd_t    drv_cmd;
	enc_cmd_t    seen_cmd;
	enc_result_t want;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp16(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic int bump16(input int v);
		return (v >= 65535) ? 65535 : v + 1;
	endfunction

	// Step per {previous, current} code pair
	function automatic int quad_delta(input int idx);
		case (idx)
			1, 7, 8, 14:  return 1;
			2, 4, 11, 13: return -1;
			default:      return 0;
		endcase
	endfunction

	function automatic int gray_of(input int pos);
		case (pos)
			0:       return 0;
			1:       return 1;
			2:       return 3;
			default: return 2;
		endcase
	endfunction

	function automatic int pos_of(input int code);
		case (code)
			0:       return 0;
			1:       return 1;
			3:       return 2;
			default: return 3;
		endcase
	endfunction

	function automatic void reset_shadow();
		cfg_spn = SPN_RST;
		cfg_debounce = DEB_RST;
		cfg_hold = HOLD_RST;
		cfg_invert = 0;
		micro_acc = 0;
		notch_acc = 0;
		enc_prev = 0;
		enc_primed = 0;
		btn_last_raw = 0;
		btn_stable = 0;
		press_active = 0;
		click_armed = 0;
		click_pending = 0;
		hold_done = 0;
		quiet_ticks = 0;
		press_ticks = 0;
	endfunction

	// Advance the shadow state by one command and return its response
	function automatic enc_result_t decode_command(input enc_cmd_t c);
		enc_result_t r;
		int code, delta, spn, n;
		r.turn_dir = TURN_NONE;
		r.steps_value = '0;
		r.click = 1'b0;
		r.hold = 1'b0;
		case (c.op)
			OP_PIN: begin
				code = {c.pin_a, c.pin_b};
				if (!enc_primed) begin
					enc_prev = code;
					enc_primed = 1;
				end else if (code != enc_prev) begin
					delta = quad_delta(enc_prev * 4 + code);
					enc_prev = code;
					if (cfg_invert != 0)
						delta = -delta;
					micro_acc = clamp16(micro_acc + delta);
				end
			end
			OP_TICK: begin
				// move whole notches out of the micro-step accumulator
				spn = (cfg_spn == 0) ? 1 : cfg_spn;
				if (micro_acc >= spn) begin
					n = micro_acc / spn;
					micro_acc -= n * spn;
					notch_acc = clamp16(notch_acc + n);
				end else if (micro_acc <= -spn) begin
					n = (-micro_acc) / spn;
					micro_acc += n * spn;
					notch_acc = clamp16(notch_acc - n);
				end
				// debounce
				quiet_ticks = bump16(quiet_ticks);
				if (press_active)
					press_ticks = bump16(press_ticks);
				if (c.button_down != btn_last_raw) begin
					btn_last_raw = c.button_down;
					quiet_ticks = 0;
				end
				if (quiet_ticks >= cfg_debounce && c.button_down != btn_stable) begin
					btn_stable = c.button_down;
					if (c.button_down) begin
						click_armed = 1;
						press_ticks = 0;
						press_active = 1;
					end else begin
						if (click_armed)
							click_pending = 1;
						click_armed = 0;
						press_ticks = 0;
						press_active = 0;
						hold_done = 0;
					end
				end
			end
			OP_TURN: begin
				if (notch_acc > 0) begin
					notch_acc--;
					r.turn_dir = TURN_RIGHT;
				end else if (notch_acc < 0) begin
					notch_acc++;
					r.turn_dir = TURN_LEFT;
				end
			end
			OP_STEPS: begin
				r.steps_value = notch_acc[CNT_W-1:0];
				notch_acc = 0;
			end
			OP_CLICK: begin
				if (click_pending) begin
					click_pending = 0;
					r.click = 1'b1;
				end
			end
			OP_HOLD: begin
				if (btn_stable && press_active && !hold_done && press_ticks >= cfg_hold) begin
					hold_done = 1;
					r.hold = 1'b1;
				end
			end
			default: ;
		endcase
		r.pressed = btn_stable;
		return r;
	endfunction

	// Command driver
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			tx_gap <= 0;
		end else if (cmd_ch.valid && !cmd_ch.ready) begin
			// hold the pending transaction
		end else if (tx_gap != 0) begin
			tx_gap <= tx_gap - 1;
			cmd_ch.valid <= 1'b0;
		end else if (gaps_on && encoder_cmds.size() != 0
				&& $urandom_range(1, 100) <= tx_gap_pct) begin
			tx_gap <= $urandom_range(0, 8);
			cmd_ch.valid <= 1'b0;
		end else if (encoder_cmds.size() != 0) begin
			drv_cmd = encoder_cmds.pop_front();
			cmd_ch.valid <= 1'b1;
			cmd_ch.op <= drv_cmd.op;
			cmd_ch.pin_a <= drv_cmd.pin_a;
			cmd_ch.pin_b <= drv_cmd.pin_b;
			cmd_ch.button_down <= drv_cmd.button_down;
		end else begin
			cmd_ch.valid <= 1'b0;
		end
	end

	// Response backpressure
	always @(posedge clk) begin
		if (!arst_n || !gaps_on) begin
			rx_stall <= 0;
			rsp_ch.ready <= 1'b1;
		end else if (rx_stall != 0) begin
			rx_stall <= rx_stall - 1;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(1, 100) <= rx_gap_pct) begin
			rx_stall <= $urandom_range(0, 8);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Gap density changes per segment; a zero rate gives stretches with no gaps
	always @(posedge clk) begin
		if (seg_left == 0) begin
			seg_left <= $urandom_range(40, 400);
			tx_gap_pct <= 15 * $urandom_range(0, 2);
			rx_gap_pct <= 15 * $urandom_range(0, 2);
		end else begin
			seg_left <= seg_left - 1;
		end
	end

	// Monitor: check responses, predict accepted commands
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_checked++;
				if (awaited_results.size() == 0) begin
					$error("response transaction with no command outstanding");
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (rsp_ch.turn_dir !== want.turn_dir) begin
						$error("turn_dir: expected %0d, actual %0d", want.turn_dir, rsp_ch.turn_dir);
						fail_count++;
					end
					if (rsp_ch.steps_value !== want.steps_value) begin
						$error("steps_value: expected %0d, actual %0d",
							want.steps_value, rsp_ch.steps_value);
						fail_count++;
					end
					if (rsp_ch.click !== want.click) begin
						$error("click: expected %0d, actual %0d", want.click, rsp_ch.click);
						fail_count++;
					end
					if (rsp_ch.hold !== want.hold) begin
						$error("hold: expected %0d, actual %0d", want.hold, rsp_ch.hold);
						fail_count++;
					end
					if (rsp_ch.pressed !== want.pressed) begin
						$error("pressed: expected %0d, actual %0d", want.pressed, rsp_ch.pressed);
						fail_count++;
					end
					if (want.turn_dir != TURN_NONE)
						turns_seen++;
					if (want.click)
						clicks_seen++;
					if (want.hold)
						holds_seen++;
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				seen_cmd.op = cmd_ch.op;
				seen_cmd.pin_a = cmd_ch.pin_a;
				seen_cmd.pin_b = cmd_ch.pin_b;
				seen_cmd.button_down = cmd_ch.button_down;
				awaited_results.push_back(decode_command(seen_cmd));
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_cmd(input logic [2:0] op, input bit a, input bit b, input bit btn);
		enc_cmd_t c;
		c.op = op;
		c.pin_a = a;
		c.pin_b = b;
		c.button_down = btn;
		encoder_cmds.push_back(c);
	endtask

	task automatic push_op(input logic [2:0] op);
		push_cmd(op, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
	endtask

	task automatic push_tick(input bit btn);
		push_cmd(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1), btn);
	endtask

	task automatic push_pin_code(input int code);
		push_cmd(OP_PIN, code[1], code[0], $urandom_range(0, 1));
		gen_pos = pos_of(code);
	endtask

	task automatic step_encoder(input bit fwd);
		push_pin_code(gray_of((gen_pos + (fwd ? 1 : 3)) % 4));
	endtask

	// Wait for the block to go idle, then let the tick latency pass
	task automatic wait_drained();
		do @(negedge clk);
		while (encoder_cmds.size() != 0 || cmd_ch.valid || awaited_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SPN:    cfg_spn = value[SPN_W-1:0];
			REG_DEB:    cfg_debounce = value[DEB_W-1:0];
			REG_HOLD:   cfg_hold = value[CNT_W-1:0];
			REG_INVERT: cfg_invert = value[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int spn, input int deb, input int hold, input int inv);
		write_reg(REG_SPN, spn);
		write_reg(REG_DEB, deb);
		write_reg(REG_HOLD, hold);
		write_reg(REG_INVERT, inv);
		config_count++;
		@(negedge clk);
	endtask

	// Random mix: rotations with glitches, button activity with bounce, reads, spare ops
	task automatic rand_phase(input int target);
		int made, len, pick;
		bit fwd;
		made = 0;
		while (made < target) begin
			pick = $urandom_range(0, 9);
			if (pick <= 3) begin
				fwd = $urandom_range(0, 1);
				len = $urandom_range(1, 12);
				repeat (len) begin
					if ($urandom_range(0, 15) == 0)
						push_pin_code($urandom_range(0, 3));
					else
						step_encoder(fwd);
				end
				made += len;
			end else if (pick <= 6) begin
				if ($urandom_range(0, 2) == 0)
					gen_btn = !gen_btn;
				len = $urandom_range(1, cfg_debounce + 8);
				repeat (len) begin
					push_tick(($urandom_range(0, 9) == 0) ? !gen_btn : gen_btn);
					if ($urandom_range(0, 3) == 0) begin
						push_op(OP_HOLD);
						made++;
					end
				end
				made += len;
			end else if (pick <= 8) begin
				case ($urandom_range(0, 3))
					0:       push_op(OP_TURN);
					1:       push_op(OP_STEPS);
					2:       push_op(OP_CLICK);
					default: push_op(OP_HOLD);
				endcase
				made++;
			end else begin
				push_op($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO);
				made++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = OP_PIN;
		cmd_ch.pin_a = 1'b0;
		cmd_ch.pin_b = 1'b0;
		cmd_ch.button_down = 1'b0;
		rsp_ch.ready = 1'b1;
		gaps_on = 1;
		gen_pos = 0;
		gen_btn = 0;
		reset_shadow();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reads at reset, spare ops, first and repeated samples, both directions
		push_cmd(OP_TURN, 0, 0, 0);
		push_cmd(OP_STEPS, 1, 1, 1);
		push_cmd(OP_CLICK, 0, 1, 0);
		push_cmd(OP_HOLD, 1, 0, 1);
		push_cmd(OP_SPARE_LO, 1, 0, 1);
		push_cmd(OP_SPARE_HI, 0, 1, 0);
		push_pin_code(3);
		push_pin_code(3);
		push_pin_code(2);
		push_pin_code(0);
		push_pin_code(1);
		push_pin_code(3);
		push_pin_code(0);
		push_tick(0);
		push_op(OP_TURN);
		push_op(OP_TURN);
		push_pin_code(2);
		push_pin_code(3);
		push_pin_code(1);
		push_pin_code(0);
		push_pin_code(2);
		push_tick(1);
		push_op(OP_STEPS);
		wait_drained();

		// Random phases over several register settings
		set_config(1, 0, 0, 0);
		rand_phase(110);
		wait_drained();
		set_config(8, 3, 5, 1);
		rand_phase(110);
		wait_drained();
		set_config(0, 1, 65535, 0);
		rand_phase(110);
		wait_drained();
		set_config(15, 2, 3, 1);
		rand_phase(110);
		wait_drained();
		set_config($urandom_range(0, 15), $urandom_range(0, 6), $urandom_range(0, 40),
			$urandom_range(0, 1));
		rand_phase(110);
		wait_drained();

		// Long debounce: bounce, long press reaching hold, long release firing click
		set_config(7, 100, 60, 0);
		repeat (3) push_tick(1);
		repeat (2) push_tick(0);
		for (int i = 0; i < 180; i++) begin
			push_tick(1);
			if (i % 20 == 0)
				push_op(OP_HOLD);
			if (i % 60 == 0)
				repeat (9) step_encoder(1);
		end
		for (int i = 0; i < 120; i++) begin
			push_tick(0);
			if (i % 30 == 0)
				push_op(OP_CLICK);
		end
		push_op(OP_CLICK);
		push_op(OP_HOLD);
		push_op(OP_STEPS);
		gen_btn = 0;
		wait_drained();

		// Closing stretch with no idling on either side
		gaps_on = 0;
		set_config(1, 0, 0, 0);
		rand_phase(100);
		push_op(OP_TURN);
		push_op(OP_STEPS);
		wait_drained();

		if (awaited_results.size() != 0) begin
			$error("%0d responses never arrived", awaited_results.size());
			fail_count++;
		end
		$display("Run covered %0d responses over %0d register settings,", results_checked,
			config_count);
		$display("with %0d notch turns, %0d clicks and %0d holds reported.", turns_seen,
			clicks_seen, holds_seen);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- rotary_encoder_button_interface.f -----
rtl/rebi_pkg.sv
rtl/rebi_if.sv
rtl/rebi_apb_regs.sv
rtl/rebi_div.sv
rtl/rebi_button.sv
rtl/rotary_encoder_button_interface.sv
tb/sv/testbench.sv
